// ----- rtl/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// Coalesced hash table package
// Operation and status codes, configuration defaults and register addresses used by the table module.
// ----------------------------------------------------------------------------
package cht_pkg;
   localparam logic [1:0] OP_LOOKUP = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   localparam logic [1:0] ST_DONE    = 2'd0;
   localparam logic [1:0] ST_MISSING = 2'd1;
   localparam logic [1:0] ST_PRESENT = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam int unsigned MIN_TABLE_LOG  = 4;
   localparam int unsigned RESET_HIGH_MUL = 192;
   localparam int unsigned FILL_SHIFT     = 8;

   localparam logic [1:0] REG_TABLE_LOG = 2'd0;
   localparam logic [1:0] REG_FILL_MUL  = 2'd1;
endpackage

// ----- rtl/cht_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module cht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/coalesced_hash_table.sv -----
// ----------------------------------------------------------------------------
// Coalesced hash table
// From start, each memory read (chain node or free-slot probe) passes through
// S_RD, S_WT and S_EV; the home slot is evaluated once more when it holds its
// own chain; the write sequence and S_RESP follow; a full insert skips to S_RESP.
// Throughput is one request at a time; busy marks the interval.
// Reset (synchronous) runs the link clear pass over all 2^MAX_SIZE_LOG slots with
// busy high; a size change runs the same pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module coalesced_hash_table
   import cht_pkg::*;
#(
   parameter int MAX_SIZE_LOG = 10,
   parameter int KEY_BITS     = 32,
   parameter int VALUE_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_operation,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [31:0]             req_key_hash,
   input  logic [VALUE_BITS-1:0]   req_value,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [VALUE_BITS-1:0]   rsp_found_value,
   output logic [MAX_SIZE_LOG-1:0] rsp_slot,
   output logic [MAX_SIZE_LOG:0]   rsp_entry_count,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [2:0]              paddr,
   input  logic [31:0]             pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   localparam int SL = MAX_SIZE_LOG;
   localparam int LW = SL + 1;
   localparam int NS = 1 << SL;
   localparam logic [LW-1:0] LFREE = {LW{1'b1}};
   localparam logic [LW-1:0] LEND  = {{SL{1'b1}}, 1'b0};
   localparam logic [3:0] SL4 = 4'(SL);

   // State codes.
   localparam logic [4:0] S_CLEAR = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_RD    = 5'd2;   // issue read of cur
   localparam logic [4:0] S_WT    = 5'd3;   // wait latency
   localparam logic [4:0] S_EV    = 5'd4;   // data valid at cur
   localparam logic [4:0] S_WR    = 5'd5;   // write sequence
   localparam logic [4:0] S_RESP  = 5'd6;

   // Phases of the request.
   localparam logic [3:0] P_HOME   = 4'd0;  // read home slot
   localparam logic [3:0] P_FIND   = 4'd1;  // chain walk for key
   localparam logic [3:0] P_TAIL   = 4'd2;  // walk to tail
   localparam logic [3:0] P_FREEUP = 4'd3;
   localparam logic [3:0] P_PRED   = 4'd4;  // walk foreign chain to pred of h
   localparam logic [3:0] P_FREEDN = 4'd5;
   localparam logic [3:0] P_NEXT   = 4'd6;  // read second node for remove

   // Write sequence kinds.
   localparam logic [2:0] W_NEW    = 3'd0;  // new entry at pos (+ link t)
   localparam logic [2:0] W_MOVE   = 3'd1;  // copy h to nf, link r, then new
   localparam logic [2:0] W_UNLINK = 3'd2;  // link pred, free idx
   localparam logic [2:0] W_PULL   = 3'd3;  // copy n2 to idx, free n2
   localparam logic [2:0] W_NONE   = 3'd4;

   logic [4:0]  state_ff, state_in;
   logic [3:0]  phase_ff, phase_in;
   logic [2:0]  wkind_ff, wkind_in;
   logic [1:0]  wstep_ff, wstep_in;
   logic [3:0]  size_ff, size_in;
   logic [7:0]  mul_ff, mul_in;
   logic [SL:0] fill_ff, fill_in;
   logic [SL:0] steps_ff, steps_in;
   logic [SL-1:0] cur_ff, cur_in, aux_ff, aux_in, pred_ff, pred_in;
   logic        pred_ok_ff, pred_ok_in;
   logic [SL-1:0] start_ff, start_in;
   logic [1:0]  op_ff, op_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [SL-1:0] hh_ff, hh_in;
   logic [SL-1:0] hfull_ff, hfull_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [LW-1:0] lnk_ff, lnk_in;    // saved link
   logic [KEY_BITS-1:0] ck_ff, ck_in;
   logic [VALUE_BITS-1:0] cv_ff, cv_in;
   logic [SL-1:0] chome_ff, chome_in;
   logic [1:0]  st_ff, st_in;
   logic [VALUE_BITS-1:0] fv_ff, fv_in;
   logic [SL-1:0] slot_ff, slot_in;
   logic        rv_ff, rv_in;

   // RAM ports
   logic              we;
   logic [SL-1:0]     wa, ra;
   logic              wk, wv, wh;
   logic [KEY_BITS-1:0] wkd, rkd;
   logic [VALUE_BITS-1:0] wvd, rvd;
   logic [SL-1:0]     whd, rhd;
   logic [LW-1:0]     wld, rld;

   cht_ram #(.WIDTH(KEY_BITS), .DEPTH(NS)) u_key (
      .clock, .wr_en(wk), .wr_addr(wa), .wr_data(wkd), .rd_addr(ra), .rd_data(rkd));
   cht_ram #(.WIDTH(VALUE_BITS), .DEPTH(NS)) u_val (
      .clock, .wr_en(wv), .wr_addr(wa), .wr_data(wvd), .rd_addr(ra), .rd_data(rvd));
   cht_ram #(.WIDTH(SL), .DEPTH(NS)) u_home (
      .clock, .wr_en(wh), .wr_addr(wa), .wr_data(whd), .rd_addr(ra), .rd_data(rhd));
   cht_ram #(.WIDTH(LW), .DEPTH(NS)) u_link (
      .clock, .wr_en(we), .wr_addr(wa), .wr_data(wld), .rd_addr(ra), .rd_data(rld));

   logic [SL-1:0] m;
   logic [SL:0]   limit;
   logic [SL+8:0] prod;
   logic          cfg_wr;
   logic [3:0]    cl;

   assign m = SL'((NS - 1) >> (SL4 - size_ff));
   assign prod = (SL+9)'(mul_ff) * ((SL+9)'(m) + (SL+9)'(1));
   assign limit = prod[SL+8:FILL_SHIFT];
   assign cfg_wr = psel && penable && pwrite;
   assign pready = 1'b1;
   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cl = pwdata[3:0];
      if (cl < 4'(MIN_TABLE_LOG)) cl = 4'(MIN_TABLE_LOG);
      if (cl > SL4) cl = SL4;
   end

   always_comb begin
      case (paddr[2])
         1'b0: prdata = {28'd0, size_ff};
         default: prdata = {24'd0, mul_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         size_ff  <= 4'(MIN_TABLE_LOG);
         mul_ff   <= 8'(RESET_HIGH_MUL);
         fill_ff  <= '0;
         cur_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         size_ff  <= size_in;
         mul_ff   <= mul_in;
         fill_ff  <= fill_in;
         cur_ff   <= cur_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in; wkind_ff <= wkind_in; wstep_ff <= wstep_in;
      steps_ff <= steps_in; aux_ff <= aux_in; pred_ff <= pred_in;
      pred_ok_ff <= pred_ok_in; start_ff <= start_in; op_ff <= op_in;
      key_ff <= key_in; hh_ff <= hh_in; hfull_ff <= hfull_in; val_ff <= val_in;
      lnk_ff <= lnk_in; ck_ff <= ck_in; cv_ff <= cv_in; chome_ff <= chome_in;
      st_ff <= st_in; fv_ff <= fv_in; slot_ff <= slot_in;
   end

   logic [SL-1:0] nxt_up, nxt_dn;
   assign nxt_up = (cur_ff + SL'(1)) & m;
   assign nxt_dn = (cur_ff + m) & m;

   always_comb begin
      state_in = state_ff; phase_in = phase_ff; wkind_in = wkind_ff;
      wstep_in = wstep_ff; size_in = size_ff; mul_in = mul_ff;
      fill_in = fill_ff; steps_in = steps_ff; cur_in = cur_ff;
      aux_in = aux_ff; pred_in = pred_ff; pred_ok_in = pred_ok_ff;
      start_in = start_ff; op_in = op_ff; key_in = key_ff; hh_in = hh_ff;
      hfull_in = hfull_ff; val_in = val_ff; lnk_in = lnk_ff; ck_in = ck_ff;
      cv_in = cv_ff; chome_in = chome_ff; st_in = st_ff; fv_in = fv_ff;
      slot_in = slot_ff; rv_in = 1'b0;
      we = 1'b0; wk = 1'b0; wv = 1'b0; wh = 1'b0;
      wa = cur_ff; ra = cur_ff;
      wkd = key_ff; wvd = val_ff; whd = hfull_ff; wld = LEND;

      if (cfg_wr && paddr[2] == REG_FILL_MUL[0]) mul_in = pwdata[7:0];
      if (cfg_wr && paddr[2] == REG_TABLE_LOG[0] && cl != size_ff) begin
         size_in = cl;
         fill_in = '0;
         cur_in = '0;
         state_in = S_CLEAR;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               we = 1'b1; wa = cur_ff; wld = LFREE;
               cur_in = cur_ff + SL'(1);
               if (cur_ff == SL'(NS - 1)) state_in = S_IDLE;
            end
            S_IDLE: begin
               if (start) begin
                  op_in = req_operation; key_in = req_key; val_in = req_value;
                  hh_in = req_key_hash[SL-1:0] & m;
                  hfull_in = req_key_hash[SL-1:0];
                  cur_in = req_key_hash[SL-1:0] & m;
                  steps_in = '0; pred_ok_in = 1'b0;
                  st_in = ST_MISSING; fv_in = '0; slot_in = '0;
                  if (req_operation == OP_INSERT &&
                      fill_ff + (SL+1)'(1) > limit) begin
                     st_in = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     phase_in = (req_operation == OP_INSERT) ? P_HOME : P_FIND;
                     state_in = S_RD;
                  end
               end
            end
            S_RD: state_in = S_WT;
            S_WT: state_in = S_EV;
            S_EV: begin
               state_in = S_RD;
               case (phase_ff)
                  P_HOME: begin
                     if (rld == LFREE) begin
                        aux_in = hh_ff; wkind_in = W_NEW; wstep_in = 2'd1;
                        state_in = S_WR;
                     end else if ((rhd & m) != hh_ff) begin
                        ck_in = rkd; cv_in = rvd; chome_in = rhd; lnk_in = rld;
                        cur_in = rhd & m; steps_in = '0; phase_in = P_PRED;
                     end else begin
                        phase_in = P_FIND; state_in = S_EV;  // same data
                     end
                  end
                  P_FIND: begin
                     if (rld != LFREE && rkd == key_ff) begin
                        slot_in = cur_ff; st_in = ST_DONE;
                        lnk_in = rld;
                        case (op_ff)
                           OP_INSERT: begin
                              st_in = ST_PRESENT; state_in = S_RESP;
                           end
                           OP_REMOVE: begin
                              aux_in = cur_ff;
                              if (pred_ok_ff) begin
                                 wkind_in = W_UNLINK; wstep_in = 2'd0;
                                 state_in = S_WR;
                              end else if (rld != LEND) begin
                                 cur_in = rld[SL-1:0] & m; phase_in = P_NEXT;
                              end else begin
                                 wkind_in = W_UNLINK; wstep_in = 2'd1;
                                 state_in = S_WR;
                              end
                           end
                           default: begin
                              fv_in = rvd; state_in = S_RESP;
                           end
                        endcase
                     end else begin
                        pred_in = cur_ff; pred_ok_in = 1'b1;
                        steps_in = steps_ff + (SL+1)'(1);
                        if (rld[SL] || steps_ff + (SL+1)'(1) > (SL+1)'(m)) begin
                           if (op_ff == OP_INSERT) begin
                              // walk from home to tail again
                              cur_in = hh_ff; steps_in = '0; phase_in = P_TAIL;
                           end else begin
                              state_in = S_RESP;
                           end
                        end else begin
                           cur_in = rld[SL-1:0] & m;
                        end
                     end
                  end
                  P_TAIL: begin
                     if (rld[SL] || steps_ff > (SL+1)'(m)) begin
                        pred_in = cur_ff; start_in = cur_ff;
                        cur_in = nxt_up; steps_in = '0; phase_in = P_FREEUP;
                     end else begin
                        cur_in = rld[SL-1:0] & m;
                        steps_in = steps_ff + (SL+1)'(1);
                     end
                  end
                  P_FREEUP: begin
                     if (rld == LFREE || steps_ff >= (SL+1)'(m)) begin
                        aux_in = (rld == LFREE) ? cur_ff : start_ff;
                        wkind_in = W_NEW; wstep_in = 2'd0; state_in = S_WR;
                     end else begin
                        cur_in = nxt_up; steps_in = steps_ff + (SL+1)'(1);
                     end
                  end
                  P_PRED: begin
                     if (rld == {1'b0, hh_ff} || steps_ff > (SL+1)'(m) || rld[SL]) begin
                        pred_in = cur_ff; start_in = cur_ff;
                        cur_in = nxt_dn; steps_in = '0; phase_in = P_FREEDN;
                     end else begin
                        cur_in = rld[SL-1:0] & m;
                        steps_in = steps_ff + (SL+1)'(1);
                     end
                  end
                  P_FREEDN: begin
                     if (rld == LFREE || steps_ff >= (SL+1)'(m)) begin
                        aux_in = (rld == LFREE) ? cur_ff : start_ff;
                        wkind_in = W_MOVE; wstep_in = 2'd0; state_in = S_WR;
                     end else begin
                        cur_in = nxt_dn; steps_in = steps_ff + (SL+1)'(1);
                     end
                  end
                  P_NEXT: begin
                     ck_in = rkd; cv_in = rvd; chome_in = rhd; lnk_in = rld;
                     wkind_in = W_PULL; wstep_in = 2'd0; state_in = S_WR;
                  end
                  default: state_in = S_RESP;
               endcase
            end
            S_WR: begin
               wstep_in = wstep_ff + 2'd1;
               case (wkind_ff)
                  W_NEW: begin
                     if (wstep_ff == 2'd0) begin
                        we = 1'b1; wa = pred_ff; wld = {1'b0, aux_ff};
                     end else begin
                        we = 1'b1; wk = 1'b1; wv = 1'b1; wh = 1'b1;
                        wa = aux_ff; wld = LEND;
                        fill_in = fill_ff + (SL+1)'(1);
                        st_in = ST_DONE; slot_in = aux_ff;
                        state_in = S_RESP;
                     end
                  end
                  W_MOVE: begin
                     if (wstep_ff == 2'd0) begin
                        we = 1'b1; wk = 1'b1; wv = 1'b1; wh = 1'b1;
                        wa = aux_ff; wkd = ck_ff; wvd = cv_ff; whd = chome_ff;
                        wld = lnk_ff;
                     end else begin
                        we = 1'b1; wa = pred_ff; wld = {1'b0, aux_ff};
                        aux_in = hh_ff; wkind_in = W_NEW; wstep_in = 2'd1;
                     end
                  end
                  W_UNLINK: begin
                     if (wstep_ff == 2'd0) begin
                        we = 1'b1; wa = pred_ff; wld = lnk_ff;
                     end else begin
                        we = 1'b1; wa = aux_ff; wld = LFREE;
                        wkind_in = W_NONE;
                     end
                  end
                  W_PULL: begin
                     if (wstep_ff == 2'd0) begin
                        we = 1'b1; wk = 1'b1; wv = 1'b1; wh = 1'b1;
                        wa = aux_ff; wkd = ck_ff; wvd = cv_ff; whd = chome_ff;
                        wld = lnk_ff;
                     end else begin
                        we = 1'b1; wa = cur_ff; wld = LFREE;
                        wkind_in = W_NONE;
                     end
                  end
                  default: begin
                     if (fill_ff != '0) fill_in = fill_ff - (SL+1)'(1);
                     state_in = S_RESP;
                  end
               endcase
            end
            S_RESP: begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
            default: state_in = S_IDLE;
         endcase
      end
   end

   assign rsp_valid       = rv_ff;
   assign rsp_status      = st_ff;
   assign rsp_found_value = fv_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_entry_count = fill_ff;
endmodule
